[src/rit_pkg.sv]
// ----------------------------------------------------------------------------
// Reference-counted identifier table package
// Shared field widths, operation and status codes, item structs and the
// sequencer state type.
// ----------------------------------------------------------------------------
package rit_pkg;

    localparam int IDENT_W         = 31;
    localparam int INDEX_W         = 6;
    localparam int OP_W            = 2;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int REF_BITS_DEF    = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 2'd0,
        OP_DISCARD = 2'd1,
        OP_GET     = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LOOK,
        S_WRITE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [IDENT_W-1:0] ident_number;
        logic [INDEX_W-1:0] slot_index;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] result_index;
        logic [IDENT_W-1:0] result_ident;
        status_t            status;
    } out_item_t;

endpackage

[src/rit_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle; read data is registered.
// ----------------------------------------------------------------------------
module rit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[src/refcounted_ident_table_top.sv]
// ----------------------------------------------------------------------------
// Reference-counted identifier table
// Add: scans the filled entries, one entry read per cycle through the
//   single RAM port with registered read data, then write (none if full) and result.
// Discard: look, write if live, result; get: look, result; rejected: result only.
//   One item at a time; a result waiting on m_ready holds off the next item.
// Reset (aresetn low, synchronous) empties the table by clearing the fill
//   count; the RAM itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module refcounted_ident_table_top #(
    parameter int TABLE_DEPTH = rit_pkg::TABLE_DEPTH_DEF,
    parameter int REF_BITS    = rit_pkg::REF_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rit_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rit_pkg::out_item_t m_data
);

    // Each table entry is one RAM word: live bit, reference count, identifier.
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > rit_pkg::INDEX_W) ? CW : rit_pkg::INDEX_W;
    localparam int EW = 1 + REF_BITS + rit_pkg::IDENT_W;
    localparam int REFS_LSB = rit_pkg::IDENT_W;

    rit_pkg::state_t state_reg, state_next;

    // Item held while it is worked on.
    logic [rit_pkg::OP_W-1:0]    op_reg, op_next;
    logic [rit_pkg::IDENT_W-1:0] ident_reg, ident_next;
    logic [rit_pkg::INDEX_W-1:0] idx_reg, idx_next;

    // Scan pipeline: rd_idx issues reads, chk_idx names the entry whose data
    // is on the RAM output in this cycle.
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;
    logic          have_blank_reg, have_blank_next;
    logic [AW-1:0] blank_reg, blank_next;

    logic [CW-1:0] used_count_reg, used_count_next;

    // Pending write and pending result.
    logic [AW-1:0]      wr_addr_reg, wr_addr_next;
    logic [EW-1:0]      wr_word_reg, wr_word_next;
    rit_pkg::out_item_t res_reg, res_next;

    logic               m_valid_reg, m_valid_next;
    rit_pkg::out_item_t m_data_reg, m_data_next;

    // RAM port.
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;

    logic                        rd_live;
    logic [REF_BITS-1:0]         rd_refs;
    logic [rit_pkg::IDENT_W-1:0] rd_ident;
    logic [REF_BITS-1:0]         refs_inc;
    logic [REF_BITS-1:0]         refs_dec;

    logic in_range;
    logic scan_match;
    logic scan_done;
    logic table_full;
    logic out_free;

    rit_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign rd_live  = ram_rdata[EW-1];
    assign rd_refs  = ram_rdata[REFS_LSB +: REF_BITS];
    assign rd_ident = ram_rdata[rit_pkg::IDENT_W-1:0];

    // Counts saturate at all ones going up and stop at zero going down.
    assign refs_inc = (rd_refs == {REF_BITS{1'b1}}) ? rd_refs : rd_refs + REF_BITS'(1);
    assign refs_dec = (rd_refs == '0) ? rd_refs : rd_refs - REF_BITS'(1);

    // Only entries below the fill count have ever been written.
    assign in_range   = XW'(s_data.slot_index) < XW'(used_count_reg);
    assign scan_match = chk_valid_reg && rd_live && (rd_ident == ident_reg);
    assign scan_done  = !chk_valid_reg && (rd_idx_reg >= used_count_reg);
    assign table_full = used_count_reg == CW'(TABLE_DEPTH);
    assign out_free   = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == rit_pkg::S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rit_pkg::S_IDLE: begin
                if (s_valid) begin
                    if (s_data.operation == rit_pkg::OP_ADD) begin
                        state_next = rit_pkg::S_SCAN;
                    end else if ((s_data.operation == rit_pkg::OP_DISCARD ||
                                  s_data.operation == rit_pkg::OP_GET) && in_range) begin
                        state_next = rit_pkg::S_LOOK;
                    end else begin
                        state_next = rit_pkg::S_RESP;
                    end
                end
            end
            rit_pkg::S_SCAN: begin
                if (scan_match) begin
                    state_next = rit_pkg::S_WRITE;
                end else if (scan_done) begin
                    if (!have_blank_reg && table_full) begin
                        state_next = rit_pkg::S_RESP;
                    end else begin
                        state_next = rit_pkg::S_WRITE;
                    end
                end
            end
            rit_pkg::S_LOOK: begin
                if (rd_live && op_reg == rit_pkg::OP_DISCARD) begin
                    state_next = rit_pkg::S_WRITE;
                end else begin
                    state_next = rit_pkg::S_RESP;
                end
            end
            rit_pkg::S_WRITE: begin
                state_next = rit_pkg::S_RESP;
            end
            rit_pkg::S_RESP: begin
                if (out_free) begin
                    state_next = rit_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rit_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and RAM control for each state.
    always_comb begin
        op_next         = op_reg;
        ident_next      = ident_reg;
        idx_next        = idx_reg;
        rd_idx_next     = rd_idx_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        have_blank_next = have_blank_reg;
        blank_next      = blank_reg;
        used_count_next = used_count_reg;
        wr_addr_next    = wr_addr_reg;
        wr_word_next    = wr_word_reg;
        res_next        = res_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        ram_we          = 1'b0;
        ram_addr        = rd_idx_reg[AW-1:0];
        ram_wdata       = wr_word_reg;

        unique case (state_reg)
            rit_pkg::S_IDLE: begin
                ram_addr = AW'(s_data.slot_index);
                if (s_valid) begin
                    op_next         = s_data.operation;
                    ident_next      = s_data.ident_number;
                    idx_next        = s_data.slot_index;
                    rd_idx_next     = '0;
                    chk_valid_next  = 1'b0;
                    have_blank_next = 1'b0;
                    // A rejected discard or get, or an unused code, answers now.
                    res_next.result_index = s_data.slot_index;
                    res_next.result_ident = '0;
                    res_next.status       = rit_pkg::ST_BAD;
                end
            end
            rit_pkg::S_SCAN: begin
                if (chk_valid_reg && !rd_live) begin
                    // Later blanks override earlier ones: highest index wins.
                    have_blank_next = 1'b1;
                    blank_next      = chk_idx_reg;
                end
                if (scan_match) begin
                    wr_addr_next          = chk_idx_reg;
                    wr_word_next          = {1'b1, refs_inc, rd_ident};
                    res_next.result_index = rit_pkg::INDEX_W'(chk_idx_reg);
                    res_next.result_ident = ident_reg;
                    res_next.status       = rit_pkg::ST_OK;
                end else if (scan_done) begin
                    res_next.result_ident = ident_reg;
                    res_next.status       = rit_pkg::ST_OK;
                    if (have_blank_reg) begin
                        wr_addr_next          = blank_reg;
                        wr_word_next          = {1'b1, REF_BITS'(1), ident_reg};
                        res_next.result_index = rit_pkg::INDEX_W'(blank_reg);
                    end else if (table_full) begin
                        res_next.result_index = '0;
                        res_next.result_ident = '0;
                        res_next.status       = rit_pkg::ST_FULL;
                    end else begin
                        wr_addr_next          = used_count_reg[AW-1:0];
                        wr_word_next          = {1'b1, REF_BITS'(1), ident_reg};
                        res_next.result_index = rit_pkg::INDEX_W'(used_count_reg[AW-1:0]);
                        used_count_next       = used_count_reg + CW'(1);
                    end
                end else begin
                    // Issue the next read while the previous entry is checked.
                    if (rd_idx_reg < used_count_reg) begin
                        chk_valid_next = 1'b1;
                        chk_idx_next   = rd_idx_reg[AW-1:0];
                        rd_idx_next    = rd_idx_reg + CW'(1);
                    end else begin
                        chk_valid_next = 1'b0;
                    end
                end
            end
            rit_pkg::S_LOOK: begin
                res_next.result_index = idx_reg;
                if (!rd_live) begin
                    res_next.result_ident = '0;
                    res_next.status       = rit_pkg::ST_BAD;
                end else begin
                    res_next.result_ident = rd_ident;
                    res_next.status       = rit_pkg::ST_OK;
                    wr_addr_next          = AW'(idx_reg);
                    wr_word_next          = {refs_dec != '0, refs_dec, rd_ident};
                end
            end
            rit_pkg::S_WRITE: begin
                ram_we    = 1'b1;
                ram_addr  = wr_addr_reg;
                ram_wdata = wr_word_reg;
            end
            rit_pkg::S_RESP: begin
                if (out_free) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rit_pkg::S_IDLE;
            used_count_reg <= '0;
            m_valid_reg    <= 1'b0;
            chk_valid_reg  <= 1'b0;
            have_blank_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
            m_valid_reg    <= m_valid_next;
            chk_valid_reg  <= chk_valid_next;
            have_blank_reg <= have_blank_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        ident_reg   <= ident_next;
        idx_reg     <= idx_next;
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        blank_reg   <= blank_next;
        wr_addr_reg <= wr_addr_next;
        wr_word_reg <= wr_word_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

endmodule
